// ===== src/chs_pkg.sv =====
// shared types and constants of the chained hash set
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

   localparam int KEY_W    = 32;
   localparam int BUCKET_W = 4;
   localparam int DIGIT_W  = 4;
   localparam int DIGITS   = KEY_W / DIGIT_W;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [BUCKET_W-1:0] bucket;
      logic                pool_full;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/chs_if.sv =====
// request and response channel interfaces of the chained hash set
`timescale 1ns / 1ps
`default_nettype none

interface chs_req_if;
   logic             valid;
   logic             ready;
   chs_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface chs_rsp_if;
   logic             valid;
   logic             ready;
   chs_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/chs_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module chs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/chs_mod.sv =====
// iterative key modulo bucket count, one hex digit per cycle
`timescale 1ns / 1ps
`default_nettype none

module chs_mod #(
   parameter int BUCKETS = 15
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            start,
   input  wire logic [chs_pkg::KEY_W-1:0]                       key,
   output logic                                                 done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0]     remainder
);

   import chs_pkg::*;

   localparam int RW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int MW    = RW + DIGIT_W;
   localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int MAX_K = (1 << DIGIT_W) - 1;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [RW-1:0]    rem_ff, rem_in;

   logic [MW-1:0]    partial;
   logic [MW-1:0]    sub;
   logic [MW-1:0]    diff;
   logic             last;

   // partial = rem * 16 + digit, then strip the largest multiple of BUCKETS
   always_comb begin
      partial = {rem_ff, key_ff[KEY_W-1 -: DIGIT_W]};
      sub     = '0;
      for (int k = 1; k <= MAX_K; k++) begin
         if (partial >= MW'(k * BUCKETS)) begin
            sub = MW'(k * BUCKETS);
         end
      end
      diff = partial - sub;
   end

   assign last = run_ff && (cnt_ff == CNT_W'(DIGITS - 1));

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      key_in  = key_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         key_in = key;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = diff[RW-1:0];
         key_in = key_ff << DIGIT_W;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      key_ff <= key_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/chained_hash_set.sv =====
// top level of the chained hash set with a fixed node pool
// Hash set of 32-bit unsigned keys with separate chaining. Each request is an
// insert (op 0) or a search (op 1) and gives exactly one response carrying the
// bucket (key mod BUCKETS, cut to 4 bits), found for a search, and pool_full
// for an insert refused because all POOL_NODES nodes are taken. Inserts link
// a new node at the head of the bucket chain; duplicate keys are kept. One
// request is worked at a time: ready is high only while the sequencer is idle.
// A request passes through these steps, and the next request is taken once
// the sequencer is idle again: the remainder unit folds one hex digit per
// cycle and registers done with the final remainder, the bucket head is then
// read from its ram, the node ram delivers one chain node per cycle during a
// search walk, and one state loads the response. The response sits in an
// output register, so the next request is taken while a response still waits;
// a response stall holds the block only while that register is still full at
// the load.
// No clearing pass is needed after reset: heads use valid bits, nodes a fill
// count.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_set #(
   parameter int BUCKETS    = 15,
   parameter int POOL_NODES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   chs_req_if.sink    req_chan,
   chs_rsp_if.source  rsp_chan
);

   import chs_pkg::*;

   // index and link widths; the null link is POOL_NODES itself
   localparam int RW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int LW  = $clog2(POOL_NODES + 1);
   localparam int NDW = KEY_W + LW;
   localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOD   = 3'd1;
   localparam logic [2:0] S_HEAD  = 3'd2;
   localparam logic [2:0] S_HEADW = 3'd3;
   localparam logic [2:0] S_WALK  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [RW-1:0]      bucket_ff, bucket_in;
   logic               found_ff, found_in;
   logic               full_ff, full_in;
   logic [LW-1:0]      used_ff, used_in;
   logic [BUCKETS-1:0] head_valid_ff, head_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               rsp_load;
   logic               mod_done;
   logic [RW-1:0]      mod_rem;

   logic               head_rd_en;
   logic               head_wr_en;
   logic [LW-1:0]      head_rdata;
   logic [LW-1:0]      head_link;

   logic               node_rd_en;
   logic               node_wr_en;
   logic [NDW-1:0]     node_rdata;
   logic [KEY_W-1:0]   node_key;
   logic [LW-1:0]      node_link;
   logic [LW-1:0]      walk_link;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // bucket remainder unit
   chs_mod #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer),
      .key       (req_chan.data.key),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // chain head per bucket; an entry without its valid bit is the null link
   chs_ram #(
      .WIDTH (LW),
      .DEPTH (BUCKETS)
   ) u_heads (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (used_ff),
      .rd_en   (head_rd_en),
      .rd_addr (bucket_ff),
      .rd_data (head_rdata)
   );

   // node pool: key and next link side by side
   chs_ram #(
      .WIDTH (NDW),
      .DEPTH (POOL_NODES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (used_ff[NW-1:0]),
      .wr_data ({key_ff, head_link}),
      .rd_en   (node_rd_en),
      .rd_addr (walk_link[NW-1:0]),
      .rd_data (node_rdata)
   );

   assign head_link = head_valid_ff[bucket_ff] ? head_rdata : NULL_LINK;
   assign node_key  = node_rdata[NDW-1 -: KEY_W];
   assign node_link = node_rdata[LW-1:0];

   // next node to fetch: the head right after the head read, else the link
   assign walk_link = (state_ff == S_HEADW) ? head_link : node_link;

   assign head_rd_en = (state_ff == S_HEAD);
   assign head_wr_en = (state_ff == S_HEADW) && (op_ff == OP_INSERT)
                       && (used_ff != NULL_LINK);
   assign node_wr_en = head_wr_en;

   // a node is fetched only if the link names a taken node
   always_comb begin
      node_rd_en = 1'b0;
      if ((state_ff == S_HEADW) && (op_ff == OP_SEARCH) && (head_link < used_ff)) begin
         node_rd_en = 1'b1;
      end else if ((state_ff == S_WALK) && (node_key != key_ff)
                   && (node_link < used_ff)) begin
         node_rd_en = 1'b1;
      end
   end

   // response register is free when empty or when its transfer goes now
   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      used_in       = used_ff;
      head_valid_in = head_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in    = req_chan.data.op;
               key_in   = req_chan.data.key;
               found_in = 1'b0;
               full_in  = 1'b0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               bucket_in = mod_rem;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = S_HEADW;
         end
         S_HEADW: begin
            if (op_ff == OP_INSERT) begin
               if (used_ff == NULL_LINK) begin
                  full_in = 1'b1;
               end else begin
                  // new node becomes the head, old head its link
                  head_valid_in[bucket_ff] = 1'b1;
                  used_in = used_ff + LW'(1);
               end
               state_in = S_FIN;
            end else if (node_rd_en) begin
               state_in = S_WALK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WALK: begin
            if (node_key == key_ff) begin
               found_in = 1'b1;
               state_in = S_FIN;
            end else if (!node_rd_en) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.found     = found_ff;
         rsp_data_in.bucket    = BUCKET_W'(bucket_ff);
         rsp_data_in.pool_full = full_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         head_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      bucket_ff   <= bucket_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // fill count never passes the pool size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NULL_LINK)
      else $error("node fill count beyond pool size");

   // every insert write takes exactly one node
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      node_wr_en |=> used_ff == $past(used_ff) + LW'(1))
      else $error("fill count not advanced by insert");

   // walk state always sees data of a read issued the cycle before
   a_walk_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> $past(node_rd_en))
      else $error("chain walk without node read");

   // a refused insert never reports a hit
   a_full_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.pool_full |-> !rsp_chan.data.found)
      else $error("pool full response flagged as found");

   // a request transfer starts the remainder unit
   a_accept_mod: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_MOD)
      else $error("request transfer did not start bucket computation");

endmodule

`default_nettype wire
